>>> src/clipped_colorkey_sprite_blit_top_assert.svh
// assertion macros shared by the blitter rtl
`ifndef CLIPPED_COLORKEY_SPRITE_BLIT_TOP_ASSERT_SVH
`define CLIPPED_COLORKEY_SPRITE_BLIT_TOP_ASSERT_SVH

// property must hold at every edge outside reset
`define CCSB_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent must hold in the cycle after the trigger
`define CCSB_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

>>> src/ccsb_pkg.sv
// types and constants of the colour-key sprite blitter
package ccsb_pkg;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [1:0] CSR_KEY      = 2'd2;

   localparam logic [31:0] CLEAR_VALUE = 32'h0000_0000;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ADDR  = 5'b00010,
      S_MEM   = 5'b00100,
      S_DONE  = 5'b01000,
      S_CLEAR = 5'b10000
   } state_type;

   // control from the sequencer to the frame buffer
   typedef struct packed {
      logic clear_start;
      logic we;
      logic re;
   } fb_ctrl_type;

endpackage

>>> src/ccsb_if.sv
// channel interfaces of the colour-key sprite blitter

interface ccsb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] sprite_x;
   logic [15:0] sprite_y;
   logic [11:0] sprite_col;
   logic [11:0] sprite_row;
   logic [31:0] pixel_value;
   logic [8:0]  read_x;
   logic [7:0]  read_y;

   modport source (output valid, command, sprite_x, sprite_y, sprite_col, sprite_row,
                   pixel_value, read_x, read_y, input ready);
   modport sink (input valid, command, sprite_x, sprite_y, sprite_col, sprite_row,
                 pixel_value, read_x, read_y, output ready);
endinterface

interface ccsb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_pixel;
   logic        pixel_written;

   modport source (output valid, read_pixel, pixel_written, input ready);
   modport sink (input valid, read_pixel, pixel_written, output ready);
endinterface

interface ccsb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/clipped_colorkey_sprite_blit_top.sv
// top level of the colour-key sprite blitter with clipping
`include "clipped_colorkey_sprite_blit_top_assert.svh"
// Colour-key sprite blitter over a SCREEN_W x SCREEN_H frame buffer of 32-bit pixels held
// in one single-port synchronous memory. Each transaction on the request channel is a
// command: clear zeroes the whole buffer, draw places one sprite pixel at world position
// (sprite_x + sprite_col, sprite_y + sprite_row) shifted by the camera origin and writes it
// when it lands on screen and differs from the transparent key, read returns the pixel at
// (read_x, read_y). Every command gives exactly one response transaction. Draw, read and the
// unused command go from acceptance to a loaded response through coordinate add on accept,
// range check and row multiply in ADDR, memory access in MEM and read data in DONE, where
// the sequencer holds while the response register is full and not taken; it handles one item
// at a time. A clear is the single memory write port sweeping the buffer one pixel per cycle. After
// reset the same sweep runs with req ready low; csr writes are taken throughout. The response
// register lets a new request be accepted while the previous result still waits.
module clipped_colorkey_sprite_blit_top import ccsb_pkg::*; #(
   parameter int SCREEN_W = 400,
   parameter int SCREEN_H = 250
) (
   input  logic        clock,
   input  logic        reset,
   ccsb_req_if.sink    req_if,
   ccsb_rsp_if.source  rsp_if,
   ccsb_csr_if.sink    csr_if
);
   localparam int Depth = SCREEN_W * SCREEN_H;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int XW    = (SCREEN_W > 1) ? $clog2(SCREEN_W) : 1;
   localparam int YW    = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;

   // configuration registers
   logic signed [15:0] origin_x_ff;
   logic signed [15:0] origin_y_ff;
   logic [31:0]        key_ff;

   // sequencer state and the item in flight
   state_type          state_ff, state_in;
   cmd_type            cmd_ff;
   logic signed [17:0] x_ff, y_ff;
   logic [31:0]        pix_ff;
   logic               opaque_ff;
   logic               we_ff, re_ff;
   logic [AddrW-1:0]   addr_ff;
   logic               clr_rsp_ff;

   // response register
   logic        rsp_valid_ff;
   logic [31:0] rsp_read_pixel_ff;
   logic        rsp_pixel_written_ff;

   logic               req_accept;
   logic               out_load;
   logic signed [17:0] draw_x, draw_y;
   logic               in_range;
   logic [AddrW-1:0]   addr_in;
   fb_ctrl_type        fb_ctrl;
   logic               fb_busy;
   logic [31:0]        fb_rdata;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   // csr writes, index beyond the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         key_ff      <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_ORIGIN_X: origin_x_ff <= csr_if.data[15:0];
            CSR_ORIGIN_Y: origin_y_ff <= csr_if.data[15:0];
            CSR_KEY:      key_ff      <= csr_if.data;
            default:      ;
         endcase
      end
   end

   // screen coordinates at full width, no wrap: 18 bits cover every operand mix
   assign draw_x = $signed({{2{req_if.sprite_x[15]}}, req_if.sprite_x})
                 + $signed({6'b0, req_if.sprite_col})
                 - $signed({{2{origin_x_ff[15]}}, origin_x_ff});
   assign draw_y = $signed({{2{req_if.sprite_y[15]}}, req_if.sprite_y})
                 + $signed({6'b0, req_if.sprite_row})
                 - $signed({{2{origin_y_ff[15]}}, origin_y_ff});

   // clip test, horizontal bound against the screen width and vertical bound against the screen height
   assign in_range = !x_ff[17] && (x_ff[16:0] < 17'(SCREEN_W))
                  && !y_ff[17] && (y_ff[16:0] < 17'(SCREEN_H));

   // row-major address, multiply by a constant width
   assign addr_in = AddrW'(AddrW'(y_ff[YW-1:0]) * AddrW'(SCREEN_W))
                  + AddrW'(x_ff[XW-1:0]);

   // capture the accepted transaction, and the address in ADDR
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff    <= cmd_type'(req_if.command);
         pix_ff    <= req_if.pixel_value;
         opaque_ff <= (req_if.pixel_value != key_ff);
         if (cmd_type'(req_if.command) == CMD_DRAW) begin
            x_ff <= draw_x;
            y_ff <= draw_y;
         end else begin
            x_ff <= $signed({9'b0, req_if.read_x});
            y_ff <= $signed({10'b0, req_if.read_y});
         end
      end
      if (state_ff == S_ADDR) begin
         addr_ff <= addr_in;
      end
   end

   // access enables: dropped on accept so a clear reports neither
   always_ff @(posedge clock) begin
      if (reset) begin
         we_ff <= 1'b0;
         re_ff <= 1'b0;
      end else if (req_accept) begin
         we_ff <= 1'b0;
         re_ff <= 1'b0;
      end else if (state_ff == S_ADDR) begin
         we_ff <= (cmd_ff == CMD_DRAW) && in_range && opaque_ff;
         re_ff <= (cmd_ff == CMD_READ) && in_range;
      end
   end

   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (cmd_type'(req_if.command) == CMD_CLEAR) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_ADDR;
               end
            end
         end
         S_ADDR:  state_in = S_MEM;
         S_MEM:   state_in = S_DONE;
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            if (!fb_busy) begin
               state_in = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept && cmd_type'(req_if.command) == CMD_CLEAR) begin
            clr_rsp_ff <= 1'b1;
         end else if (state_ff == S_CLEAR && !fb_busy) begin
            clr_rsp_ff <= 1'b0;
         end
      end
   end

   // frame buffer access
   assign fb_ctrl.clear_start = req_accept && (cmd_type'(req_if.command) == CMD_CLEAR);
   assign fb_ctrl.we          = (state_ff == S_MEM) && we_ff;
   assign fb_ctrl.re          = (state_ff == S_MEM) && re_ff;

   ccsb_fbuf #(
      .Depth (Depth)
   ) u_fbuf (
      .clock (clock),
      .reset (reset),
      .ctrl  (fb_ctrl),
      .addr  (addr_ff),
      .wdata (pix_ff),
      .busy  (fb_busy),
      .rdata (fb_rdata)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_read_pixel_ff    <= re_ff ? fb_rdata : '0;
         rsp_pixel_written_ff <= we_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.read_pixel    = rsp_read_pixel_ff;
   assign rsp_if.pixel_written = rsp_pixel_written_ff;

   `CCSB_ASSERT_HOLDS(a_no_req_during_sweep, clock, reset, fb_busy |-> !req_if.ready, "request taken during clear sweep")
   `CCSB_ASSERT_HOLDS(a_write_only_on_draw, clock, reset, fb_ctrl.we |-> (cmd_ff == CMD_DRAW), "buffer written by a non-draw command")
   `CCSB_ASSERT_NEXT(a_pixel_zero_unless_read, clock, reset, out_load && !re_ff, rsp_if.read_pixel == '0, "non-zero pixel without a read")
   `CCSB_ASSERT_NEXT(a_written_flag_matches, clock, reset, out_load, rsp_if.pixel_written == $past(we_ff), "written flag differs from write enable")

endmodule

>>> src/ccsb_fbuf.sv
// frame buffer memory with its clearing sweep
module ccsb_fbuf import ccsb_pkg::*; #(
   parameter int Depth = 100000,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fb_ctrl_type              ctrl,
   input  logic [AddrW-1:0]         addr,
   input  logic [31:0]              wdata,
   output logic                     busy,
   output logic [31:0]              rdata
);
   logic [31:0]      mem [Depth];
   logic [AddrW-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [31:0]      rdata_ff;

   // sweep counter, restarted by reset or a clear
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctrl.clear_start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == AddrW'(Depth - 1)) begin
            busy_in = 1'b0;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[cnt_ff] <= CLEAR_VALUE;
      end else if (ctrl.we) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.re && !busy_ff) begin
         rdata_ff <= mem[addr];
      end
   end

   assign busy  = busy_ff;
   assign rdata = rdata_ff;

endmodule
